[hdl/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 4;
    localparam int ST_W      = 2;
    localparam int SHAMT_W   = 5;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_MOD  = 4'd5,
        OP_LAND = 4'd6,
        OP_LOR  = 4'd7,
        OP_NE   = 4'd8,
        OP_LT   = 4'd9,
        OP_GT   = 4'd10,
        OP_LE   = 4'd11,
        OP_GE   = 4'd12,
        OP_SHL  = 4'd13,
        OP_SHR  = 4'd14,
        OP_END  = 4'd15
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DIV  = 1'b1
    } pse_state_t;

    typedef enum logic [1:0] {
        SK_HOLD = 2'd0,
        SK_PUSH = 2'd1,
        SK_POP  = 2'd2
    } stack_op_t;

    typedef enum logic [1:0] {
        CC_HOLD  = 2'd0,
        CC_ABOVE = 2'd1,
        CC_BELOW = 2'd2
    } cell_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[hdl/pse_cell.sv]
// ----------------------------------------------------------------------------
// pse_cell
// One stack entry: holds, takes the word from the cell above or below.
// ----------------------------------------------------------------------------
module pse_cell (
    input  logic                              aclk,
    input  pse_pkg::cell_cmd_t                cmd,
    input  logic [pse_pkg::DATA_W-1:0]        above_word,
    input  logic [pse_pkg::DATA_W-1:0]        below_word,
    output logic [pse_pkg::DATA_W-1:0]        word_out
);
    import pse_pkg::*;

    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] word_next;

    always_comb begin
        unique case (cmd)
            CC_HOLD:  word_next = word_reg;
            CC_ABOVE: word_next = above_word;
            CC_BELOW: word_next = below_word;
            default:  word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;

endmodule

[hdl/pse_div.sv]
// ----------------------------------------------------------------------------
// pse_div
// Radix-2 restoring divider for unsigned 32-bit magnitudes, one bit a cycle.
// ----------------------------------------------------------------------------
module pse_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [pse_pkg::DATA_W-1:0]        dividend,
    input  logic [pse_pkg::DATA_W-1:0]        divisor,
    output pse_pkg::div_status_t              status,
    output logic [pse_pkg::DATA_W-1:0]        quotient,
    output logic [pse_pkg::DATA_W-1:0]        remainder
);
    import pse_pkg::*;

    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DATA_W:0]      trial;
    logic                 stepping;
    logic                 finished;

    assign finished = busy_reg && (cnt_reg == DIV_CNT_W'(DIV_STEPS));
    assign stepping = busy_reg && !finished;
    assign trial    = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (stepping) begin
            if (!trial[DATA_W]) begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
        end else if (finished) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = finished;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

[hdl/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Postfix expression evaluator on a shift-cell stack of signed 32-bit words.
// ----------------------------------------------------------------------------
// Tokens arrive on the slave side, the opcode in s_tuser and the pushed value
// in s_tdata. The stack is a row of STACK_DEPTH cells that shift down on a push
// and up on a pop, so the two operands always sit in the top two cells. A push
// and every operator except divide and modulo complete in the cycle the word is
// accepted: one word per cycle while s_tready is high. Divide and modulo run
// through a radix-2 divider that resolves one quotient bit per cycle; s_tready
// is low while they run. An end token or an error loads the output register;
// while that result waits on m_tready, s_tready stays low, and the next word
// may enter in the cycle the result is taken.
// Errors clear the stack and report zero with a nonzero status.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_value
    input  logic [3:0]  s_tuser,   // [3:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [1:0]  m_tuser    // [1:0] status
);
    import pse_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    pse_state_t        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg, m_tdata_next;
    status_t           m_tuser_reg, m_tuser_next;
    logic              is_mod_reg, is_mod_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;

    logic              accept;
    op_t               op;
    logic [DATA_W-1:0] top_b;
    logic [DATA_W-1:0] top_a;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] alu_word;
    logic [DATA_W-1:0] div_word;
    logic [DATA_W-1:0] new_word;
    logic [DATA_W-1:0] product;
    logic [SHAMT_W-1:0] shamt;
    logic              a_lt_b;
    logic              b_lt_a;
    stack_op_t         stack_op;
    logic              out_load;
    logic [DATA_W-1:0] out_value;
    status_t           out_status;
    logic              div_start;
    div_status_t       div_stat;
    logic [DATA_W-1:0] div_quo;
    logic [DATA_W-1:0] div_rem;

    logic [DATA_W-1:0] cell_word [STACK_DEPTH];
    cell_cmd_t         cell_cmd  [STACK_DEPTH];

    assign op       = op_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign top_b   = cell_word[0];
    assign top_a   = cell_word[1];
    assign mag_a   = top_a[DATA_W-1] ? (DATA_W'(0) - top_a) : top_a;
    assign mag_b   = top_b[DATA_W-1] ? (DATA_W'(0) - top_b) : top_b;
    assign shamt   = top_b[SHAMT_W-1:0];
    assign product = top_a * top_b;
    assign a_lt_b  = $signed(top_a) < $signed(top_b);
    assign b_lt_a  = $signed(top_b) < $signed(top_a);

    always_comb begin
        unique case (op)
            OP_ADD:  alu_word = top_a + top_b;
            OP_SUB:  alu_word = top_a - top_b;
            OP_MUL:  alu_word = product;
            OP_LAND: alu_word = DATA_W'((top_a != '0) && (top_b != '0));
            OP_LOR:  alu_word = DATA_W'((top_a != '0) || (top_b != '0));
            OP_NE:   alu_word = DATA_W'(top_a != top_b);
            OP_LT:   alu_word = DATA_W'(a_lt_b);
            OP_GT:   alu_word = DATA_W'(b_lt_a);
            OP_LE:   alu_word = DATA_W'(!b_lt_a);
            OP_GE:   alu_word = DATA_W'(!a_lt_b);
            OP_SHL:  alu_word = top_a << shamt;
            OP_SHR:  alu_word = DATA_W'($signed(top_a) >>> shamt);
            OP_PUSH, OP_DIV, OP_MOD, OP_END: alu_word = '0;
        endcase
    end

    always_comb begin
        if (is_mod_reg) begin
            div_word = neg_r_reg ? (DATA_W'(0) - div_rem) : div_rem;
        end else begin
            div_word = neg_q_reg ? (DATA_W'(0) - div_quo) : div_quo;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (op == OP_DIV || op == OP_MOD) && count_reg >= CW'(2)
                    && top_b != '0) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // datapath control
    always_comb begin
        stack_op    = SK_HOLD;
        new_word    = alu_word;
        count_next  = count_reg;
        out_load    = 1'b0;
        out_value   = '0;
        out_status  = ST_OK;
        div_start   = 1'b0;
        is_mod_next = is_mod_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_PUSH: begin
                            if (count_reg == FULL_COUNT) begin
                                out_load   = 1'b1;
                                out_status = ST_OVERFLOW;
                                count_next = '0;
                            end else begin
                                stack_op   = SK_PUSH;
                                new_word   = s_tdata;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_END: begin
                            out_load   = 1'b1;
                            count_next = '0;
                            if (count_reg == '0) begin
                                out_status = ST_UNDERFLOW;
                            end else begin
                                out_value = top_b;
                            end
                        end
                        default: begin
                            if (count_reg < CW'(2)) begin
                                out_load   = 1'b1;
                                out_status = ST_UNDERFLOW;
                                count_next = '0;
                            end else if (op == OP_DIV || op == OP_MOD) begin
                                if (top_b == '0) begin
                                    out_load   = 1'b1;
                                    out_status = ST_DIVZERO;
                                    count_next = '0;
                                end else begin
                                    div_start   = 1'b1;
                                    is_mod_next = (op == OP_MOD);
                                    neg_q_next  = top_a[DATA_W-1] ^ top_b[DATA_W-1];
                                    neg_r_next  = top_a[DATA_W-1];
                                end
                            end else begin
                                stack_op   = SK_POP;
                                count_next = count_reg - CW'(1);
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    stack_op   = SK_POP;
                    new_word   = div_word;
                    count_next = count_reg - CW'(1);
                end
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = out_value;
            m_tuser_next  = out_status;
        end else begin
            m_tvalid_next = m_tvalid_reg && !m_tready;
            m_tdata_next  = m_tdata_reg;
            m_tuser_next  = m_tuser_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        is_mod_reg  <= is_mod_next;
        neg_q_reg   <= neg_q_next;
        neg_r_reg   <= neg_r_next;
    end

    pse_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (mag_a),
        .divisor   (mag_b),
        .status    (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [DATA_W-1:0] above_w;
            logic [DATA_W-1:0] below_w;

            if (gi == 0) begin : g_top
                assign above_w = new_word;
                always_comb begin
                    unique case (stack_op)
                        SK_PUSH, SK_POP: cell_cmd[gi] = CC_ABOVE;
                        default:         cell_cmd[gi] = CC_HOLD;
                    endcase
                end
            end else begin : g_rest
                assign above_w = cell_word[gi-1];
                always_comb begin
                    unique case (stack_op)
                        SK_PUSH: cell_cmd[gi] = CC_ABOVE;
                        SK_POP:  cell_cmd[gi] = CC_BELOW;
                        default: cell_cmd[gi] = CC_HOLD;
                    endcase
                end
            end

            if (gi == STACK_DEPTH - 1) begin : g_last
                assign below_w = '0;
            end else begin : g_mid
                assign below_w = cell_word[gi+1];
            end

            pse_cell u_cell (
                .aclk       (aclk),
                .cmd        (cell_cmd[gi]),
                .above_word (above_w),
                .below_word (below_w),
                .word_out   (cell_word[gi])
            );
        end
    endgenerate

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("stack count beyond depth");

    a_div_busy_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> state_reg == S_DIV)
        else $error("divider running outside divide state");

    a_no_accept_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> !s_tready)
        else $error("word accepted during divide");

    a_end_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_END && count_reg != '0) |=>
            (m_tvalid && m_tuser == ST_OK && count_reg == '0))
        else $error("end token did not report its result");

endmodule
